// File: rtl/bfha_pkg.sv
package bfha_pkg;

   localparam int REQ_W     = 15;
   localparam int OFS_W     = 15;
   localparam int STATUS_W  = 2;
   localparam int HDR_BYTES = 4;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_RD,
      ST_A_HDR,
      ST_S_RD,
      ST_S_HDR,
      ST_A_FIN,
      ST_A_SPLIT,
      ST_F_HDR,
      ST_R_ALLOC,
      ST_R_OK,
      ST_R_FAIL,
      ST_R_BAD
   } ctrl_state_type;

   typedef enum logic [1:0] {
      AS_POS,
      AS_SCAN,
      AS_FREE
   } addr_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_INIT,
      WR_MERGE,
      WR_TAKE,
      WR_SPLIT,
      WR_FREE
   } wr_sel_type;

   typedef struct packed {
      logic                load_req;
      addr_sel_type        addr_sel;
      wr_sel_type          wr_sel;
      logic                pos_step;
      logic                scan_from_hdr;
      logic                scan_step;
      logic                merge_close;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_code;
      logic                rsp_with_ofs;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic zero_size;
      logic free_null;
      logic free_bad;
      logic hdr_full;
      logic pos_end;
      logic scan_end;
      logic found;
      logic split;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/bfha_req_if.sv
interface bfha_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [bfha_pkg::REQ_W-1:0]  req_size;
   logic [bfha_pkg::OFS_W-1:0]  free_offset;

   modport source (output valid, func, req_size, free_offset, input ready);
   modport sink   (input valid, func, req_size, free_offset, output ready);
endinterface

// File: rtl/bfha_rsp_if.sv
interface bfha_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bfha_pkg::STATUS_W-1:0]  status;
   logic [bfha_pkg::OFS_W-1:0]     payload_offset;

   modport source (output valid, status, payload_offset, input ready);
   modport sink   (input valid, status, payload_offset, output ready);
endinterface

// File: rtl/best_fit_heap_allocator_unit.sv
// channel   dir   handshake            word
// req_port  in    valid/ready          func, req_size, free_offset
// rsp_port  out   valid/ready          status, payload_offset
//
// One request at a time, timed by the single header RAM read port. A zero size, a null
// or a bad free offset goes straight to its response; an in-range free reads its header;
// allocate reads each block header, merges each free block with the free ones after it,
// then takes the best fit, split if large enough. Next request waits for the response load.
// After reset, an init state writes the initial heap header with req_port.ready low.
// A held response word does not block the next request; it waits at its end for the slot.
module best_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES = 16384
) (
   input  logic              clock,
   input  logic              reset,
   bfha_req_if.sink          req_port,
   bfha_rsp_if.source        rsp_port
);

   bfha_pkg::cmd_type  cmd;
   bfha_pkg::stat_type stat;

   bfha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfha_dp #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .func               (req_port.func),
      .req_size           (req_port.req_size),
      .free_offset        (req_port.free_offset),
      .rsp_ready          (rsp_port.ready),
      .rsp_valid          (rsp_port.valid),
      .rsp_status         (rsp_port.status),
      .rsp_payload_offset (rsp_port.payload_offset)
   );

endmodule

// File: rtl/bfha_ram.sv
module bfha_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bfha_dp.sv
module bfha_dp #(
   parameter int HEAP_BYTES = 16384
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfha_pkg::cmd_type             cmd,
   output bfha_pkg::stat_type            stat,
   input  logic                          func,
   input  logic [bfha_pkg::REQ_W-1:0]    req_size,
   input  logic [bfha_pkg::OFS_W-1:0]    free_offset,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [bfha_pkg::STATUS_W-1:0] rsp_status,
   output logic [bfha_pkg::OFS_W-1:0]    rsp_payload_offset
);

   localparam int HEAP_WORDS = (HEAP_BYTES + 3) / 4;
   localparam int HEAP_LIMIT = HEAP_WORDS * 4;
   localparam int AW         = $clog2(HEAP_WORDS);
   localparam int SIZE_W     = $clog2(HEAP_LIMIT);
   localparam int HDR_W      = SIZE_W + 1;
   localparam int POS_W      = SIZE_W + 1;
   localparam int NEED_W     = bfha_pkg::REQ_W + 1;
   localparam int EXT_W      = (POS_W > NEED_W) ? POS_W : NEED_W;

   localparam logic [POS_W-1:0] LIMIT_P = POS_W'(HEAP_LIMIT);
   localparam logic [POS_W-1:0] HDR_P   = POS_W'(bfha_pkg::HDR_BYTES);
   localparam logic [EXT_W-1:0] HDR_E   = EXT_W'(bfha_pkg::HDR_BYTES);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  scan_ff, scan_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [POS_W-1:0]  best_pos_ff, best_pos_in;
   logic [SIZE_W-1:0] fit_size_ff, fit_size_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     free_addr_ff, free_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [bfha_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [bfha_pkg::OFS_W-1:0]    rsp_offset_ff, rsp_offset_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [HDR_W-1:0]  wr_data, rd_data;
   logic [SIZE_W-1:0] rd_size;
   logic              rd_full;
   logic [POS_W-1:0]  hdr_end, scan_nxt, merge_size;
   logic [EXT_W-1:0]  ofs_ext, ofs_word, need_ext, best_ext, diff_ext, split_pos;
   logic [EXT_W-1:0]  need_rnd, ofs_plus;
   logic [SIZE_W-1:0] take_size;
   logic              better;

   bfha_ram #(
      .WIDTH (HDR_W),
      .DEPTH (HEAP_WORDS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_size  = rd_data[SIZE_W-1:0];
   assign rd_full  = rd_data[SIZE_W];
   assign hdr_end  = pos_ff + HDR_P + POS_W'(rd_size);
   assign scan_nxt = scan_ff + HDR_P + POS_W'(rd_size);
   assign merge_size = scan_ff - pos_ff - HDR_P;

   assign ofs_ext  = EXT_W'(free_offset);
   assign ofs_word = (ofs_ext - HDR_E) >> 2;
   assign need_rnd = (EXT_W'(req_size) + EXT_W'(3)) & ~EXT_W'(3);
   assign need_ext = EXT_W'(need_ff);
   assign best_ext = EXT_W'(fit_size_ff);
   assign diff_ext = best_ext - need_ext;
   assign split_pos = EXT_W'(best_pos_ff) + HDR_E + need_ext;
   assign ofs_plus = EXT_W'(best_pos_ff) + HDR_E;
   assign take_size = stat.split ? need_ext[SIZE_W-1:0] : fit_size_ff;
   assign better = (EXT_W'(merge_size) >= need_ext)
                   && (!found_ff || (merge_size[SIZE_W-1:0] < fit_size_ff));

   always_comb begin
      stat.is_free   = (func == bfha_pkg::FUNC_FREE);
      stat.zero_size = (req_size == '0);
      stat.free_null = (free_offset == '0);
      stat.free_bad  = (free_offset[1:0] != 2'b00) || (ofs_ext < HDR_E)
                       || (ofs_word >= EXT_W'(HEAP_WORDS));
      stat.hdr_full  = rd_full;
      stat.pos_end   = (hdr_end >= LIMIT_P);
      stat.scan_end  = (scan_ff >= LIMIT_P);
      stat.found     = found_ff;
      stat.split     = (diff_ext > HDR_E);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.addr_sel)
         bfha_pkg::AS_POS:  rd_addr = pos_ff[AW+1:2];
         bfha_pkg::AS_SCAN: rd_addr = scan_ff[AW+1:2];
         default:           rd_addr = ofs_word[AW-1:0];
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = pos_ff[AW+1:2];
      wr_data = {1'b0, merge_size[SIZE_W-1:0]};
      case (cmd.wr_sel)
         bfha_pkg::WR_INIT: begin
            wr_addr = '0;
            wr_data = {1'b0, SIZE_W'(HEAP_LIMIT - bfha_pkg::HDR_BYTES)};
         end
         bfha_pkg::WR_MERGE: begin
            wr_addr = pos_ff[AW+1:2];
            wr_data = {1'b0, merge_size[SIZE_W-1:0]};
         end
         bfha_pkg::WR_TAKE: begin
            wr_addr = best_pos_ff[AW+1:2];
            wr_data = {1'b1, take_size};
         end
         bfha_pkg::WR_SPLIT: begin
            wr_addr = split_pos[AW+1:2];
            wr_data = {1'b0, SIZE_W'(diff_ext - HDR_E)};
         end
         bfha_pkg::WR_FREE: begin
            wr_addr = free_addr_ff;
            wr_data = {1'b0, rd_size};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      need_in      = need_ff;
      best_pos_in  = best_pos_ff;
      fit_size_in  = fit_size_ff;
      found_in     = found_ff;
      free_addr_in = free_addr_ff;
      if (cmd.load_req) begin
         pos_in       = '0;
         found_in     = 1'b0;
         need_in      = need_rnd[NEED_W-1:0];
         free_addr_in = ofs_word[AW-1:0];
      end
      if (cmd.pos_step) begin
         pos_in = hdr_end;
      end
      if (cmd.scan_from_hdr) begin
         scan_in = hdr_end;
      end
      if (cmd.scan_step) begin
         scan_in = scan_nxt;
      end
      if (cmd.merge_close) begin
         pos_in = scan_ff;
         if (better) begin
            found_in     = 1'b1;
            best_pos_in  = pos_ff;
            fit_size_in  = merge_size[SIZE_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_code;
         rsp_offset_in = cmd.rsp_with_ofs ? ofs_plus[bfha_pkg::OFS_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      scan_ff       <= scan_in;
      need_ff       <= need_in;
      best_pos_ff   <= best_pos_in;
      fit_size_ff   <= fit_size_in;
      free_addr_ff  <= free_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;

   a_merge_forward: assert property (@(posedge clock) disable iff (reset)
      cmd.merge_close |-> scan_ff > pos_ff)
      else $error("merge closed with scan not past block start");

   a_take_found: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_sel == bfha_pkg::WR_TAKE |-> found_ff)
      else $error("block taken without a fit");

endmodule

// File: rtl/bfha_ctrl.sv
module bfha_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bfha_pkg::stat_type stat,
   output bfha_pkg::cmd_type  cmd
);

   bfha_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfha_pkg::ST_INIT: state_in = bfha_pkg::ST_IDLE;
         bfha_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!stat.is_free) begin
                  state_in = stat.zero_size ? bfha_pkg::ST_R_FAIL : bfha_pkg::ST_A_RD;
               end else if (stat.free_null) begin
                  state_in = bfha_pkg::ST_R_OK;
               end else if (stat.free_bad) begin
                  state_in = bfha_pkg::ST_R_BAD;
               end else begin
                  state_in = bfha_pkg::ST_F_HDR;
               end
            end
         end
         bfha_pkg::ST_A_RD: state_in = bfha_pkg::ST_A_HDR;
         bfha_pkg::ST_A_HDR: begin
            if (stat.hdr_full) begin
               state_in = stat.pos_end ? bfha_pkg::ST_A_FIN : bfha_pkg::ST_A_RD;
            end else begin
               state_in = bfha_pkg::ST_S_RD;
            end
         end
         bfha_pkg::ST_S_RD: begin
            state_in = stat.scan_end ? bfha_pkg::ST_A_FIN : bfha_pkg::ST_S_HDR;
         end
         bfha_pkg::ST_S_HDR: begin
            state_in = stat.hdr_full ? bfha_pkg::ST_A_RD : bfha_pkg::ST_S_RD;
         end
         bfha_pkg::ST_A_FIN: begin
            if (!stat.found) begin
               state_in = bfha_pkg::ST_R_FAIL;
            end else begin
               state_in = stat.split ? bfha_pkg::ST_A_SPLIT : bfha_pkg::ST_R_ALLOC;
            end
         end
         bfha_pkg::ST_A_SPLIT: state_in = bfha_pkg::ST_R_ALLOC;
         bfha_pkg::ST_F_HDR: begin
            state_in = stat.hdr_full ? bfha_pkg::ST_R_OK : bfha_pkg::ST_R_BAD;
         end
         bfha_pkg::ST_R_ALLOC, bfha_pkg::ST_R_OK,
         bfha_pkg::ST_R_FAIL, bfha_pkg::ST_R_BAD: begin
            if (stat.out_free) begin
               state_in = bfha_pkg::ST_IDLE;
            end
         end
         default: state_in = bfha_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      req_ready         = 1'b0;
      cmd               = '0;
      cmd.addr_sel      = bfha_pkg::AS_POS;
      cmd.wr_sel        = bfha_pkg::WR_NONE;
      cmd.rsp_code      = bfha_pkg::STAT_OK;
      unique case (state_ff)
         bfha_pkg::ST_INIT: cmd.wr_sel = bfha_pkg::WR_INIT;
         bfha_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.addr_sel = bfha_pkg::AS_FREE;
            cmd.load_req = req_valid;
         end
         bfha_pkg::ST_A_RD: cmd.addr_sel = bfha_pkg::AS_POS;
         bfha_pkg::ST_A_HDR: begin
            cmd.pos_step      = stat.hdr_full;
            cmd.scan_from_hdr = !stat.hdr_full;
         end
         bfha_pkg::ST_S_RD: begin
            cmd.addr_sel = bfha_pkg::AS_SCAN;
            if (stat.scan_end) begin
               cmd.merge_close = 1'b1;
               cmd.wr_sel      = bfha_pkg::WR_MERGE;
            end
         end
         bfha_pkg::ST_S_HDR: begin
            if (stat.hdr_full) begin
               cmd.merge_close = 1'b1;
               cmd.wr_sel      = bfha_pkg::WR_MERGE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         bfha_pkg::ST_A_FIN: begin
            if (stat.found) begin
               cmd.wr_sel = bfha_pkg::WR_TAKE;
            end
         end
         bfha_pkg::ST_A_SPLIT: cmd.wr_sel = bfha_pkg::WR_SPLIT;
         bfha_pkg::ST_F_HDR: begin
            if (stat.hdr_full) begin
               cmd.wr_sel = bfha_pkg::WR_FREE;
            end
         end
         bfha_pkg::ST_R_ALLOC: begin
            cmd.rsp_load     = stat.out_free;
            cmd.rsp_code     = bfha_pkg::STAT_OK;
            cmd.rsp_with_ofs = 1'b1;
         end
         bfha_pkg::ST_R_OK: begin
            cmd.rsp_load = stat.out_free;
            cmd.rsp_code = bfha_pkg::STAT_OK;
         end
         bfha_pkg::ST_R_FAIL: begin
            cmd.rsp_load = stat.out_free;
            cmd.rsp_code = bfha_pkg::STAT_FAIL;
         end
         bfha_pkg::ST_R_BAD: begin
            cmd.rsp_load = stat.out_free;
            cmd.rsp_code = bfha_pkg::STAT_BAD;
         end
         default: cmd.wr_sel = bfha_pkg::WR_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfha_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_init_after_reset: assert property (@(posedge clock)
      $past(reset) |-> state_ff == bfha_pkg::ST_INIT)
      else $error("no init pass after reset");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.out_free)
      else $error("response word loaded over an untaken one");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> cmd.wr_sel == bfha_pkg::WR_NONE)
      else $error("header write while accepting a word");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int HEAP_BYTES = 16384;
   localparam int HEAP_WORDS = HEAP_BYTES / bfha_pkg::HDR_BYTES;
   localparam int RANDOM_WORDS = 1330;

   typedef struct packed {
      logic                       func;
      logic [bfha_pkg::REQ_W-1:0] req_size;
      logic [bfha_pkg::OFS_W-1:0] free_offset;
   } req_word_type;

   typedef struct packed {
      logic [bfha_pkg::STATUS_W-1:0] status;
      logic [bfha_pkg::OFS_W-1:0]    payload_offset;
   } rsp_word_type;

   typedef enum {
      PLAN_FIXED,
      PLAN_FREE_NEWEST,
      PLAN_RANDOM
   } plan_kind_type;

   typedef enum {
      NZ_ZERO_SIZE,
      NZ_HUGE_SIZE,
      NZ_RAW_SIZE,
      NZ_NULL_FREE,
      NZ_RAW_FREE,
      NZ_ODD_FREE,
      NZ_FAR_FREE,
      NZ_STALE_FREE
   } noise_kind_type;

   typedef struct {
      plan_kind_type kind;
      req_word_type  word;
   } req_plan_type;

   logic clock = 1'b0;
   logic reset;

   bfha_req_if req_bus ();
   bfha_rsp_if rsp_bus ();

   best_fit_heap_allocator_unit #(
      .HEAP_BYTES(HEAP_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   always #1 clock = ~clock;

   // heap image: one header per 4-byte word
   bit          hdr_full    [HEAP_WORDS];
   int unsigned hdr_size    [HEAP_WORDS];
   bit          hdr_written [HEAP_WORDS];

   logic [bfha_pkg::OFS_W-1:0] live_payloads[$];
   logic [bfha_pkg::OFS_W-1:0] released_payloads[$];
   rsp_word_type               awaited_rsps[$];
   req_plan_type               planned_reqs[$];

   logic req_fire;
   logic rsp_fire;
   int   words_sent = 0;
   int   rsp_count  = 0;
   int   fail_count = 0;
   int   total_words;
   int   send_gap   = 0;
   int   take_hold  = 0;
   bit   send_calm  = 1'b0;
   bit   take_calm  = 1'b0;

   function automatic void heap_clear();
      for (int i = 0; i < HEAP_WORDS; i++) begin
         hdr_full[i]    = 1'b0;
         hdr_size[i]    = 0;
         hdr_written[i] = 1'b0;
      end
      hdr_size[0]    = HEAP_BYTES - bfha_pkg::HDR_BYTES;
      hdr_written[0] = 1'b1;
   endfunction

   function automatic void hdr_write(int unsigned ofs, bit full, int unsigned size);
      if ((ofs >> 2) < HEAP_WORDS) begin
         hdr_full[ofs >> 2]    = full;
         hdr_size[ofs >> 2]    = size;
         hdr_written[ofs >> 2] = 1'b1;
      end
   endfunction

   function automatic void merge_run(int unsigned pos);
      int unsigned scan;
      scan = pos;
      while (scan < HEAP_BYTES && !hdr_full[scan >> 2])
         scan += bfha_pkg::HDR_BYTES + hdr_size[scan >> 2];
      hdr_write(pos, 1'b0, scan - pos - bfha_pkg::HDR_BYTES);
   endfunction

   function automatic rsp_word_type heap_allocate(int unsigned req);
      int unsigned  need, pos, sz, nxt, best_pos, fit_size;
      bit           found;
      rsp_word_type r;
      r.status         = bfha_pkg::STAT_FAIL;
      r.payload_offset = '0;
      if (req == 0)
         return r;
      need      = (req + 3) & ~32'd3;
      pos       = 0;
      found     = 1'b0;
      best_pos  = 0;
      fit_size  = 0;
      while (pos < HEAP_BYTES) begin
         if (!hdr_full[pos >> 2]) begin
            nxt = pos + bfha_pkg::HDR_BYTES + hdr_size[pos >> 2];
            if (nxt < HEAP_BYTES && !hdr_full[nxt >> 2])
               merge_run(pos);
         end
         sz = hdr_size[pos >> 2];
         if (!hdr_full[pos >> 2] && sz >= need && (!found || sz < fit_size)) begin
            found     = 1'b1;
            fit_size  = sz;
            best_pos  = pos;
         end
         pos += bfha_pkg::HDR_BYTES + sz;
      end
      if (!found)
         return r;
      if (fit_size - need <= bfha_pkg::HDR_BYTES)
         need = fit_size;
      hdr_write(best_pos, 1'b1, need);
      if (need != fit_size)
         hdr_write(best_pos + bfha_pkg::HDR_BYTES + need, 1'b0,
                   fit_size - need - bfha_pkg::HDR_BYTES);
      r.status         = bfha_pkg::STAT_OK;
      r.payload_offset = bfha_pkg::OFS_W'(best_pos + bfha_pkg::HDR_BYTES);
      live_payloads.push_back(r.payload_offset);
      return r;
   endfunction

   function automatic rsp_word_type heap_release(logic [bfha_pkg::OFS_W-1:0] ofs);
      int unsigned  w;
      rsp_word_type r;
      r.status         = bfha_pkg::STAT_OK;
      r.payload_offset = '0;
      if (ofs == 0)
         return r;
      r.status = bfha_pkg::STAT_BAD;
      if (ofs[1:0] != 2'b00 || ofs < bfha_pkg::HDR_BYTES)
         return r;
      w = (int'(ofs) - bfha_pkg::HDR_BYTES) >> 2;
      if (w >= HEAP_WORDS || !hdr_full[w])
         return r;
      hdr_full[w] = 1'b0;
      r.status    = bfha_pkg::STAT_OK;
      for (int i = 0; i < live_payloads.size(); i++) begin
         if (live_payloads[i] == ofs) begin
            live_payloads.delete(i);
            break;
         end
      end
      released_payloads.push_back(ofs);
      if (released_payloads.size() > 64)
         void'(released_payloads.pop_front());
      return r;
   endfunction

   function automatic rsp_word_type heap_predict(req_word_type q);
      if (q.func == bfha_pkg::FUNC_FREE)
         return heap_release(q.free_offset);
      return heap_allocate(q.req_size);
   endfunction

   function automatic int idle_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [bfha_pkg::REQ_W-1:0] alloc_size_pick();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return bfha_pkg::REQ_W'($urandom_range(1, 64));
      if (r < 88)
         return bfha_pkg::REQ_W'($urandom_range(65, 1024));
      if (r < 97)
         return bfha_pkg::REQ_W'($urandom_range(1025, 4096));
      return bfha_pkg::REQ_W'($urandom_range(4097, HEAP_BYTES - bfha_pkg::HDR_BYTES));
   endfunction

   // never aim a free at a header word that was never written
   function automatic logic [bfha_pkg::OFS_W-1:0] free_target_safe(
      logic [bfha_pkg::OFS_W-1:0] ofs);
      int unsigned w;
      if (ofs == 0 || ofs[1:0] != 2'b00)
         return ofs;
      w = (int'(ofs) - bfha_pkg::HDR_BYTES) >> 2;
      if (w < HEAP_WORDS && !hdr_written[w]) begin
         if (live_payloads.size() != 0)
            return live_payloads[$urandom_range(0, live_payloads.size() - 1)];
         ofs[0] = 1'b1;
      end
      return ofs;
   endfunction

   function automatic req_word_type noise_word(req_word_type q);
      noise_kind_type nk;
      nk = noise_kind_type'($urandom_range(0, 7));
      q.func = bfha_pkg::FUNC_FREE;
      case (nk)
         NZ_ZERO_SIZE: begin
            q.func     = bfha_pkg::FUNC_ALLOC;
            q.req_size = '0;
         end
         NZ_HUGE_SIZE: begin
            q.func     = bfha_pkg::FUNC_ALLOC;
            q.req_size = bfha_pkg::REQ_W'($urandom_range(HEAP_BYTES - 7, 32767));
         end
         NZ_RAW_SIZE:
            q.func = bfha_pkg::FUNC_ALLOC;
         NZ_NULL_FREE:
            q.free_offset = '0;
         NZ_RAW_FREE:
            q.free_offset = free_target_safe(q.free_offset);
         NZ_ODD_FREE: begin
            if (live_payloads.size() != 0)
               q.free_offset = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
            q.free_offset[1:0] = 2'($urandom_range(1, 3));
         end
         NZ_FAR_FREE:
            q.free_offset = bfha_pkg::OFS_W'($urandom_range(HEAP_WORDS + 1, 8191) << 2);
         default: begin
            if (released_payloads.size() != 0)
               q.free_offset =
                  released_payloads[$urandom_range(0, released_payloads.size() - 1)];
            else
               q.free_offset = '0;
         end
      endcase
      return q;
   endfunction

   // resolved when the word goes on the bus, so the heap image is current
   function automatic req_word_type plan_resolve(req_plan_type p);
      req_word_type q;
      int           roll;
      q.func        = bfha_pkg::FUNC_ALLOC;
      q.req_size    = bfha_pkg::REQ_W'($urandom);
      q.free_offset = bfha_pkg::OFS_W'($urandom);
      case (p.kind)
         PLAN_FIXED:
            q = p.word;
         PLAN_FREE_NEWEST: begin
            q.func        = bfha_pkg::FUNC_FREE;
            q.free_offset = (live_payloads.size() != 0) ? live_payloads[$] : '0;
         end
         default: begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
               q = noise_word(q);
            else if (live_payloads.size() == 0 ||
                     (live_payloads.size() < 40 && roll < 58)) begin
               q.func     = bfha_pkg::FUNC_ALLOC;
               q.req_size = alloc_size_pick();
            end else begin
               q.func        = bfha_pkg::FUNC_FREE;
               q.free_offset = live_payloads[$urandom_range(0, live_payloads.size() - 1)];
            end
         end
      endcase
      return q;
   endfunction

   task automatic plan_add(plan_kind_type k, logic f, int size, int ofs);
      req_plan_type p;
      p.kind             = k;
      p.word.func        = f;
      p.word.req_size    = bfha_pkg::REQ_W'(size);
      p.word.free_offset = bfha_pkg::OFS_W'(ofs);
      planned_reqs.push_back(p);
   endtask

   always @(negedge clock) begin : sender
      req_word_type w;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.func        <= bfha_pkg::FUNC_ALLOC;
         req_bus.req_size    <= '0;
         req_bus.free_offset <= '0;
      end else if (!(req_bus.valid && !req_fire)) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap--;
         end else if (planned_reqs.size() != 0) begin
            w = plan_resolve(planned_reqs.pop_front());
            req_bus.valid       <= 1'b1;
            req_bus.func        <= w.func;
            req_bus.req_size    <= w.req_size;
            req_bus.free_offset <= w.free_offset;
            if ($urandom_range(0, 49) == 0)
               send_calm = !send_calm;
            send_gap = send_calm ? 0 : idle_pick();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 49) == 0)
               take_calm = !take_calm;
            take_hold = take_calm ? 0 : idle_pick();
            // long hold-off: the unit backs up and stalls its request side
            if (rsp_count == 250 || rsp_count == 900)
               take_hold = 600;
         end
         if (take_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            take_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_word_type got, want;
      req_word_type q;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         rsp_fire <= rsp_bus.valid && rsp_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status         = rsp_bus.status;
            got.payload_offset = rsp_bus.payload_offset;
            rsp_count++;
            if (awaited_rsps.size() == 0) begin
               $display("%0t: unexpected rsp word, status %0d offset %0d",
                        $time, got.status, got.payload_offset);
               fail_count++;
            end else begin
               want = awaited_rsps.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
               if (got.payload_offset !== want.payload_offset) begin
                  $display("%0t: payload_offset mismatch, expected %0d actual %0d",
                           $time, want.payload_offset, got.payload_offset);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            q.func        = req_bus.func;
            q.req_size    = req_bus.req_size;
            q.free_offset = req_bus.free_offset;
            awaited_rsps.push_back(heap_predict(q));
            words_sent++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      heap_clear();

      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 0, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 1, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 32767, 32767);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, HEAP_BYTES, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 3);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 32767, 6);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 32764);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, HEAP_BYTES + bfha_pkg::HDR_BYTES);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 10, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 20, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 12);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 12);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 28);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 8, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 12, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 4, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 24);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 9, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, 24);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 8, 0);
      repeat (4) plan_add(PLAN_FREE_NEWEST, bfha_pkg::FUNC_FREE, 0, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, HEAP_BYTES - bfha_pkg::HDR_BYTES, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_ALLOC, 1, 0);
      plan_add(PLAN_FIXED, bfha_pkg::FUNC_FREE, 0, bfha_pkg::HDR_BYTES);
      repeat (RANDOM_WORDS) plan_add(PLAN_RANDOM, bfha_pkg::FUNC_ALLOC, 0, 0);
      total_words = planned_reqs.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_sent < total_words)
         @(negedge clock);
      while (awaited_rsps.size() != 0)
         @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: sim.f
rtl/bfha_pkg.sv
rtl/bfha_req_if.sv
rtl/bfha_rsp_if.sv
rtl/bfha_ram.sv
rtl/bfha_dp.sv
rtl/bfha_ctrl.sv
rtl/best_fit_heap_allocator_unit.sv
tb/testbench.sv
